// File: hw/rtl/srmix_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srmix_pkg: shared types and constants of the stereo receiver mixer
// Register map, routing codes, per-lane gain bundle and balance gain table.
// ----------------------------------------------------------------------------
package srmix_pkg;

  // default sample width
  localparam int SAMPLE_BITS_DEF = 16;

  // unsigned q1.15 unity gain
  localparam logic [15:0] GAIN_UNITY = 16'd32768;

  // balance travel on each side of center
  localparam logic signed [6:0] BAL_SPAN = 7'sd50;

  // register index, byte address is 4 times the index
  typedef enum logic [2:0] {
    REG_MAIN_VOLUME    = 3'd0,
    REG_SUB_VOLUME     = 3'd1,
    REG_SUB_MUTED      = 3'd2,
    REG_BALANCE_MODE   = 3'd3,
    REG_BALANCE_OFFSET = 3'd4,
    REG_LEFT_SOURCE    = 3'd5,
    REG_RIGHT_SOURCE   = 3'd6
  } reg_idx_e;

  // routing select of one output side
  typedef enum logic [1:0] {
    SRC_MAIN     = 2'd0,
    SRC_SUB      = 2'd1,
    SRC_SUM      = 2'd2,
    SRC_NEG_MAIN = 2'd3
  } src_e;

  // everything one lane needs from the register block
  typedef struct packed {
    logic [15:0] main_gain;
    logic [15:0] sub_gain;
    logic [15:0] side_gain;
    src_e        src;
  } srmix_lane_cfg_t;

  // side gain for balance position k (0..100): round(k * 32768 / 50), capped at unity
  function automatic logic [15:0] bal_gain(logic [6:0] k);
    logic [15:0] g;
    if (k >= 7'd50) begin
      g = GAIN_UNITY;
    end else begin
      unique case (k[5:0])
        6'd0:  g = 16'd0;
        6'd1:  g = 16'd655;
        6'd2:  g = 16'd1311;
        6'd3:  g = 16'd1966;
        6'd4:  g = 16'd2621;
        6'd5:  g = 16'd3277;
        6'd6:  g = 16'd3932;
        6'd7:  g = 16'd4588;
        6'd8:  g = 16'd5243;
        6'd9:  g = 16'd5898;
        6'd10: g = 16'd6554;
        6'd11: g = 16'd7209;
        6'd12: g = 16'd7864;
        6'd13: g = 16'd8520;
        6'd14: g = 16'd9175;
        6'd15: g = 16'd9830;
        6'd16: g = 16'd10486;
        6'd17: g = 16'd11141;
        6'd18: g = 16'd11796;
        6'd19: g = 16'd12452;
        6'd20: g = 16'd13107;
        6'd21: g = 16'd13763;
        6'd22: g = 16'd14418;
        6'd23: g = 16'd15073;
        6'd24: g = 16'd15729;
        6'd25: g = 16'd16384;
        6'd26: g = 16'd17039;
        6'd27: g = 16'd17695;
        6'd28: g = 16'd18350;
        6'd29: g = 16'd19005;
        6'd30: g = 16'd19661;
        6'd31: g = 16'd20316;
        6'd32: g = 16'd20972;
        6'd33: g = 16'd21627;
        6'd34: g = 16'd22282;
        6'd35: g = 16'd22938;
        6'd36: g = 16'd23593;
        6'd37: g = 16'd24248;
        6'd38: g = 16'd24904;
        6'd39: g = 16'd25559;
        6'd40: g = 16'd26214;
        6'd41: g = 16'd26870;
        6'd42: g = 16'd27525;
        6'd43: g = 16'd28180;
        6'd44: g = 16'd28836;
        6'd45: g = 16'd29491;
        6'd46: g = 16'd30147;
        6'd47: g = 16'd30802;
        6'd48: g = 16'd31457;
        6'd49: g = 16'd32113;
        default: g = GAIN_UNITY;
      endcase
    end
    return g;
  endfunction

endpackage

// File: hw/rtl/stereo_receiver_mixer.sv
`timescale 1ns / 1ps
// Each taken frame reaches the result ports through the pipeline below, marked by
// result_valid_o for one cycle.
// Throughput: one frame per cycle; busy stays low, the datapath is a fixed
// pipeline of input register, three lane stages and the output register.
// Reset clears the beat flags and loads the register defaults; no clearing pass.
// ----------------------------------------------------------------------------
// stereo_receiver_mixer: top level
// Two mixing lanes, one per side, fed from a shared input register and
// merged into one left/right result register.
// ----------------------------------------------------------------------------
module stereo_receiver_mixer import srmix_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [4:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [SAMPLE_BITS-1:0] main_sample_i,
  input  logic signed [SAMPLE_BITS-1:0] sub_sample_i,
  output logic                          result_valid_o,
  output logic signed [SAMPLE_BITS-1:0] left_out_o,
  output logic signed [SAMPLE_BITS-1:0] right_out_o
);

  srmix_lane_cfg_t               lane_cfg_l;
  srmix_lane_cfg_t               lane_cfg_r;
  logic                          in_valid_q;
  logic signed [SAMPLE_BITS-1:0] main_q;
  logic signed [SAMPLE_BITS-1:0] sub_q;
  logic                          lane_l_valid;
  logic                          lane_r_valid;
  logic signed [SAMPLE_BITS-1:0] lane_l_out;
  logic signed [SAMPLE_BITS-1:0] lane_r_out;
  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] left_q;
  logic signed [SAMPLE_BITS-1:0] right_q;

  assign busy = 1'b0;

  // register block
  srmix_cfg u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .lane_cfg_l_o (lane_cfg_l),
    .lane_cfg_r_o (lane_cfg_r)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start & ~busy;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_sample_i;
    sub_q  <= sub_sample_i;
  end

  // left lane
  srmix_lane #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_lane_l (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (lane_cfg_l),
    .valid_i (in_valid_q),
    .main_i  (main_q),
    .sub_i   (sub_q),
    .valid_o (lane_l_valid),
    .out_o   (lane_l_out)
  );

  // right lane
  srmix_lane #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_lane_r (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (lane_cfg_r),
    .valid_i (in_valid_q),
    .main_i  (main_q),
    .sub_i   (sub_q),
    .valid_o (lane_r_valid),
    .out_o   (lane_r_out)
  );

  // merge both sides into one result beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= lane_l_valid & lane_r_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    left_q  <= lane_l_out;
    right_q <= lane_r_out;
  end

  assign result_valid_o = out_valid_q;
  assign left_out_o     = left_q;
  assign right_out_o    = right_q;

endmodule

// File: hw/rtl/srmix_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srmix_cfg: register block of the stereo receiver mixer
// APB-style registers, read-back, and the registered gain and routing bundle
// that each lane uses.
// ----------------------------------------------------------------------------
module srmix_cfg import srmix_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [4:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready,
  output srmix_lane_cfg_t lane_cfg_l_o,
  output srmix_lane_cfg_t lane_cfg_r_o
);

  logic                   wr_en;
  reg_idx_e               reg_idx;
  logic [15:0]            main_volume_q;
  logic [15:0]            sub_volume_q;
  logic                   sub_muted_q;
  logic                   balance_mode_q;
  logic signed [6:0]      balance_offset_q;
  src_e                   left_source_q;
  src_e                   right_source_q;

  logic [15:0]            main_clamp;
  logic [15:0]            sub_clamp;
  logic signed [6:0]      off_clamp;
  logic signed [7:0]      k_left;
  logic signed [7:0]      k_right;
  srmix_lane_cfg_t        lane_cfg_l_d;
  srmix_lane_cfg_t        lane_cfg_r_d;
  srmix_lane_cfg_t        lane_cfg_l_q;
  srmix_lane_cfg_t        lane_cfg_r_q;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = reg_idx_e'(paddr[4:2]);

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_volume_q    <= GAIN_UNITY;
      sub_volume_q     <= GAIN_UNITY;
      sub_muted_q      <= 1'b0;
      balance_mode_q   <= 1'b0;
      balance_offset_q <= 7'sd0;
      left_source_q    <= SRC_MAIN;
      right_source_q   <= SRC_SUB;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MAIN_VOLUME:    main_volume_q    <= pwdata[15:0];
        REG_SUB_VOLUME:     sub_volume_q     <= pwdata[15:0];
        REG_SUB_MUTED:      sub_muted_q      <= pwdata[0];
        REG_BALANCE_MODE:   balance_mode_q   <= pwdata[0];
        REG_BALANCE_OFFSET: balance_offset_q <= pwdata[6:0];
        REG_LEFT_SOURCE:    left_source_q    <= src_e'(pwdata[1:0]);
        REG_RIGHT_SOURCE:   right_source_q   <= src_e'(pwdata[1:0]);
        default: ;
      endcase
    end
  end

  // read-back mux
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_MAIN_VOLUME:    prdata[15:0] = main_volume_q;
      REG_SUB_VOLUME:     prdata[15:0] = sub_volume_q;
      REG_SUB_MUTED:      prdata[0]    = sub_muted_q;
      REG_BALANCE_MODE:   prdata[0]    = balance_mode_q;
      REG_BALANCE_OFFSET: prdata[6:0]  = balance_offset_q;
      REG_LEFT_SOURCE:    prdata[1:0]  = left_source_q;
      REG_RIGHT_SOURCE:   prdata[1:0]  = right_source_q;
      default:            prdata       = '0;
    endcase
  end

  // gains above unity act as unity, offset clamped to the balance span
  always_comb begin
    main_clamp = (main_volume_q > GAIN_UNITY) ? GAIN_UNITY : main_volume_q;
    sub_clamp  = (sub_volume_q > GAIN_UNITY) ? GAIN_UNITY : sub_volume_q;
    if (balance_offset_q > BAL_SPAN) begin
      off_clamp = BAL_SPAN;
    end else if (balance_offset_q < -BAL_SPAN) begin
      off_clamp = -BAL_SPAN;
    end else begin
      off_clamp = balance_offset_q;
    end
    k_left  = 8'sd50 - {off_clamp[6], off_clamp};
    k_right = 8'sd50 + {off_clamp[6], off_clamp};
  end

  // per-lane bundle: muting routes main to both sides
  always_comb begin
    lane_cfg_l_d.main_gain = main_clamp;
    lane_cfg_r_d.main_gain = main_clamp;
    lane_cfg_l_d.sub_gain  = balance_mode_q ? main_clamp : sub_clamp;
    lane_cfg_r_d.sub_gain  = balance_mode_q ? main_clamp : sub_clamp;
    lane_cfg_l_d.side_gain = balance_mode_q ? bal_gain(k_left[6:0]) : GAIN_UNITY;
    lane_cfg_r_d.side_gain = balance_mode_q ? bal_gain(k_right[6:0]) : GAIN_UNITY;
    lane_cfg_l_d.src       = sub_muted_q ? SRC_MAIN : left_source_q;
    lane_cfg_r_d.src       = sub_muted_q ? SRC_MAIN : right_source_q;
  end

  // registered bundle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_cfg_l_q <= '{main_gain: GAIN_UNITY, sub_gain: GAIN_UNITY,
                        side_gain: GAIN_UNITY, src: SRC_MAIN};
      lane_cfg_r_q <= '{main_gain: GAIN_UNITY, sub_gain: GAIN_UNITY,
                        side_gain: GAIN_UNITY, src: SRC_SUB};
    end else begin
      lane_cfg_l_q <= lane_cfg_l_d;
      lane_cfg_r_q <= lane_cfg_r_d;
    end
  end

  assign lane_cfg_l_o = lane_cfg_l_q;
  assign lane_cfg_r_o = lane_cfg_r_q;

endmodule

// File: hw/rtl/srmix_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srmix_lane: one output side of the stereo receiver mixer
// Three-stage pipeline: receiver gain products, routing and rounding, side
// gain product; the last stage rounds and saturates combinationally.
// ----------------------------------------------------------------------------
module srmix_lane import srmix_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  srmix_lane_cfg_t               cfg_i,
  input  logic                          valid_i,
  input  logic signed [SAMPLE_BITS-1:0] main_i,
  input  logic signed [SAMPLE_BITS-1:0] sub_i,
  output logic                          valid_o,
  output logic signed [SAMPLE_BITS-1:0] out_o
);

  localparam int PW = SAMPLE_BITS + 17;  // sample times gain
  localparam int MW = SAMPLE_BITS + 18;  // routed mix
  localparam int RW = MW - 15;           // mix back at sample scale
  localparam int BW = RW + 17;           // times side gain
  localparam int OW = BW - 15;           // rounded before saturation

  localparam logic signed [OW-1:0] SatMax =
    {{(OW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [OW-1:0] SatMin =
    {{(OW-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

  logic                   v1_q, v2_q, v3_q;
  logic signed [PW-1:0]   prod_m_d, prod_m_q;
  logic signed [PW-1:0]   prod_s_d, prod_s_q;
  logic signed [MW-1:0]   mix;
  logic signed [MW-1:0]   mix_rnd;
  logic signed [RW-1:0]   lvl_d, lvl_q;
  logic signed [BW-1:0]   bal_d, bal_q;
  logic signed [BW-1:0]   bal_rnd;
  logic signed [OW-1:0]   scaled;

  // stage 1: receiver gain products
  assign prod_m_d = main_i * $signed({1'b0, cfg_i.main_gain});
  assign prod_s_d = sub_i * $signed({1'b0, cfg_i.sub_gain});

  // stage 2: routing, then round to sample scale
  always_comb begin
    unique case (cfg_i.src)
      SRC_MAIN:     mix = MW'(prod_m_q);
      SRC_SUB:      mix = MW'(prod_s_q);
      SRC_SUM:      mix = MW'(prod_m_q) + MW'(prod_s_q);
      SRC_NEG_MAIN: mix = -MW'(prod_m_q);
      default:      mix = MW'(prod_m_q);
    endcase
    mix_rnd = mix + MW'(16384);
    lvl_d   = mix_rnd[MW-1:15];
  end

  // stage 3: side gain product
  assign bal_d = lvl_q * $signed({1'b0, cfg_i.side_gain});

  // round and saturate to full scale
  always_comb begin
    bal_rnd = bal_q + BW'(16384);
    scaled  = bal_rnd[BW-1:15];
    if (scaled > SatMax) begin
      out_o = SatMax[SAMPLE_BITS-1:0];
    end else if (scaled < SatMin) begin
      out_o = SatMin[SAMPLE_BITS-1:0];
    end else begin
      out_o = scaled[SAMPLE_BITS-1:0];
    end
  end

  // beat tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    prod_m_q <= prod_m_d;
    prod_s_q <= prod_s_d;
    lvl_q    <= lvl_d;
    bal_q    <= bal_d;
  end

  assign valid_o = v3_q;

endmodule

// File: hw/rtl/srmix_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srmix_checker: port-level checks of the stereo receiver mixer
// Fixed result timing, register read-back and pready, bound to the top level.
// ----------------------------------------------------------------------------
module srmix_checker import srmix_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  input  logic        start,
  input  logic        busy,
  input  logic        result_valid_o
);

  // every taken frame gives one result beat at the end of the pipeline
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##5 result_valid_o)
    else $error("result beat missing after accepted frame");

  // no result beat without an earlier taken frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ($past(start, 5) && !$past(busy, 5)))
    else $error("result beat without an accepted frame");

  // main volume reads back what was just written
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready && paddr[4:2] == REG_MAIN_VOLUME)
    |=> (!(psel && !pwrite && paddr[4:2] == REG_MAIN_VOLUME)
         || prdata[15:0] == $past(pwdata[15:0])))
    else $error("main volume read-back mismatch");

  // configuration port never waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready dropped");

endmodule

bind stereo_receiver_mixer srmix_checker u_srmix_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .psel           (psel),
  .penable        (penable),
  .pwrite         (pwrite),
  .paddr          (paddr),
  .pwdata         (pwdata),
  .prdata         (prdata),
  .pready         (pready),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o)
);
